// ===== sv/cma_pkg.sv =====
// Shared constants, types and state codes for the centred moving-average filter.
// Used by cma_cell, cma_div and centered_moving_average; depends on nothing.
`default_nettype none

package cma_pkg;

  localparam int SPAN        = 5;
  localparam int SAMPLE_BITS = 24;

  localparam int HALF_SPAN = (SPAN - 1) / 2;
  // Prefix sums over up to SPAN samples.
  localparam int SUM_W  = SAMPLE_BITS + $clog2(SPAN);
  // Rounded magnitude fed to the divider.
  localparam int MAG_W  = SUM_W;
  // Position count and divisor, 0..SPAN.
  localparam int CNT_W  = $clog2(SPAN + 1);
  // Cell index, 0..SPAN-1.
  localparam int IDX_W  = $clog2(SPAN);
  localparam int STEP_W = $clog2(MAG_W + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } cma_state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] divisor;
  } div_ctl_t;

endpackage

`default_nettype wire

// ===== sv/cma_cell.sv =====
// One cell of the sample window: holds one sample per channel and adds it to
// the running prefix sum handed on from its neighbour. Depends on cma_pkg.
`default_nettype none

module cma_cell (
  input  wire logic             clk,
  input  wire logic             shift_en,
  input  wire cma_pkg::sample_t sample_a_in,
  input  wire cma_pkg::sample_t sample_b_in,
  input  wire cma_pkg::sum_t    psum_a_in,
  input  wire cma_pkg::sum_t    psum_b_in,
  output cma_pkg::sample_t      sample_a_out,
  output cma_pkg::sample_t      sample_b_out,
  output cma_pkg::sum_t         psum_a_out,
  output cma_pkg::sum_t         psum_b_out
);

  cma_pkg::sample_t smp_a_r, smp_a_nxt;
  cma_pkg::sample_t smp_b_r, smp_b_nxt;
  cma_pkg::sum_t    psum_a_r, psum_a_nxt;
  cma_pkg::sum_t    psum_b_r, psum_b_nxt;

  always_comb begin
    smp_a_nxt  = shift_en ? sample_a_in : smp_a_r;
    smp_b_nxt  = shift_en ? sample_b_in : smp_b_r;
    // The prefix sum settles one cell per cycle once the window holds still.
    psum_a_nxt = psum_a_in + cma_pkg::sum_t'(smp_a_r);
    psum_b_nxt = psum_b_in + cma_pkg::sum_t'(smp_b_r);
  end

  always_ff @(posedge clk) begin
    smp_a_r  <= smp_a_nxt;
    smp_b_r  <= smp_b_nxt;
    psum_a_r <= psum_a_nxt;
    psum_b_r <= psum_b_nxt;
  end

  assign sample_a_out = smp_a_r;
  assign sample_b_out = smp_b_r;
  assign psum_a_out   = psum_a_r;
  assign psum_b_out   = psum_b_r;

endmodule

`default_nettype wire

// ===== sv/cma_div.sv =====
// Bit-serial rounding divider: signed sum over a small count, rounded to
// nearest with ties away from zero, one quotient bit per cycle. Uses cma_pkg.
`default_nettype none

module cma_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cma_pkg::div_ctl_t ctl,
  input  wire cma_pkg::sum_t     sum_in,
  output cma_pkg::sample_t       quot_out,
  output logic                   done
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic                                neg_r, neg_nxt;
  logic [cma_pkg::CNT_W-1:0]           div_r, div_nxt;
  logic [cma_pkg::CNT_W-1:0]           rem_r, rem_nxt;
  logic [cma_pkg::MAG_W-1:0]           quo_r, quo_nxt;
  logic [cma_pkg::STEP_W-1:0]          step_r, step_nxt;
  logic [cma_pkg::MAG_W-1:0]           abs_sum;
  logic [cma_pkg::CNT_W:0]             trial;
  logic                                fits;

  always_comb begin
    abs_sum  = sum_in[cma_pkg::SUM_W-1] ? cma_pkg::MAG_W'(-sum_in) : cma_pkg::MAG_W'(sum_in);
    trial    = {rem_r, quo_r[cma_pkg::MAG_W-1]};
    fits     = trial >= {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = done_r;
    neg_nxt  = neg_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      neg_nxt  = sum_in[cma_pkg::SUM_W-1];
      div_nxt  = ctl.divisor;
      rem_nxt  = '0;
      // Adding half the divisor before truncating gives round-half-away.
      quo_nxt  = abs_sum + cma_pkg::MAG_W'(ctl.divisor >> 1);
      step_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? cma_pkg::CNT_W'(trial - {1'b0, div_r}) : cma_pkg::CNT_W'(trial);
      quo_nxt  = {quo_r[cma_pkg::MAG_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == cma_pkg::STEP_W'(cma_pkg::MAG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

  assign quot_out = neg_r ? -cma_pkg::sample_t'(quo_r[cma_pkg::SAMPLE_BITS-1:0])
                          :  cma_pkg::sample_t'(quo_r[cma_pkg::SAMPLE_BITS-1:0]);
  assign done     = done_r;

endmodule

`default_nettype wire

// ===== sv/centered_moving_average.sv =====
// Centred moving-average filter with edge shrink: top level, control sequencer
// and output register. Depends on cma_pkg, cma_cell and cma_div.
//
//   channel  | direction | handshake            | payload
//   in_      | sink      | in_valid / in_stall   | sample_a, sample_b, last_sample
//   out_     | source    | out_valid / out_stall | average_a, average_b, sequence_end,
//            |           |                       | burst_last
//   cfg_     | sink      | cfg_write             | cfg_data (channel_mode)
//
// An input sample that produces no result is taken without the sequencer
// leaving ST_IDLE. One that produces results passes through ST_SUM while the
// prefix sums ripple along the cell chain, then through ST_LOAD, ST_DIV for the
// MAG_W steps of the bit-serial divider and ST_EMIT, once per result.
// Reset is synchronous and active low; it clears the sequencer, position count,
// divider control, output valid and channel mode. A stalled output holds its
// transfer, and the sequencer waits for the output register to free up before
// presenting the next result, so in_stall stays high for the whole burst.
`default_nettype none

module centered_moving_average (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire cma_pkg::sample_t in_sample_a,
  input  wire cma_pkg::sample_t in_sample_b,
  input  wire logic             in_last_sample,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output cma_pkg::sample_t      out_average_a,
  output cma_pkg::sample_t      out_average_b,
  output logic                  out_sequence_end,
  output logic                  out_burst_last,
  input  wire logic             cfg_write,
  input  wire logic             cfg_data
);

  localparam int CW = cma_pkg::CNT_W;
  localparam int IW = cma_pkg::IDX_W;

  // Sequencer state and per-item context.
  cma_pkg::cma_state_t state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;   // samples held in this sequence
  logic [CW-1:0]       c_r, c_nxt;           // count seen by the current item
  logic [CW-1:0]       d_r, d_nxt;           // age of the position being emitted
  logic                last_r, last_nxt;
  logic [IW-1:0]       sum_cnt_r, sum_cnt_nxt;
  logic                mode_r;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  cma_pkg::sample_t    avg_a_r, avg_a_nxt;
  cma_pkg::sample_t    avg_b_r, avg_b_nxt;
  logic                seq_end_r, seq_end_nxt;
  logic                burst_last_r, burst_last_nxt;

  // Cell chain.
  cma_pkg::sample_t    smp_a_w [cma_pkg::SPAN];
  cma_pkg::sample_t    smp_b_w [cma_pkg::SPAN];
  cma_pkg::sum_t       psum_a_w [cma_pkg::SPAN];
  cma_pkg::sum_t       psum_b_w [cma_pkg::SPAN];

  // Dividers.
  cma_pkg::div_ctl_t   div_ctl;
  cma_pkg::sample_t    quot_a, quot_b;
  logic                div_done_a, div_done_b;

  logic                accept;
  logic [CW-1:0]       c_acc;
  logic [CW-1:0]       cm1_acc;
  logic [CW:0]         hi_raw;
  logic [CW-1:0]       hi_cnt;
  logic [IW-1:0]       hi_w;
  logic                out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Count after this sample joins the window, saturating at SPAN.
  assign c_acc   = (count_r == CW'(cma_pkg::SPAN)) ? count_r : count_r + 1'b1;
  assign cm1_acc = c_acc - 1'b1;

  // Upper end of the clipped window: min(d + HALF_SPAN, c - 1). The lower end
  // is always the newest sample, since d never exceeds HALF_SPAN.
  assign hi_raw = {1'b0, d_r} + (CW + 1)'(cma_pkg::HALF_SPAN);
  assign hi_cnt = (hi_raw > {1'b0, c_r - 1'b1}) ? c_r - 1'b1 : CW'(hi_raw);
  assign hi_w   = hi_cnt[IW-1:0];

  // The window is a row of cells. Each cell passes its sample to the next
  // older one on every transfer, and the prefix sum ripples one cell per cycle,
  // so once the window holds still, cell k holds the sum of the k+1 newest samples.
  for (genvar k = 0; k < cma_pkg::SPAN; k++) begin : g_cell
    cma_pkg::sample_t a_in, b_in;
    cma_pkg::sum_t    pa_in, pb_in;
    if (k == 0) begin : g_head
      assign a_in  = in_sample_a;
      assign b_in  = in_sample_b;
      assign pa_in = '0;
      assign pb_in = '0;
    end else begin : g_body
      assign a_in  = smp_a_w[k-1];
      assign b_in  = smp_b_w[k-1];
      assign pa_in = psum_a_w[k-1];
      assign pb_in = psum_b_w[k-1];
    end
    cma_cell u_cell (
      .clk          (clk),
      .shift_en     (accept),
      .sample_a_in  (a_in),
      .sample_b_in  (b_in),
      .psum_a_in    (pa_in),
      .psum_b_in    (pb_in),
      .sample_a_out (smp_a_w[k]),
      .sample_b_out (smp_b_w[k]),
      .psum_a_out   (psum_a_w[k]),
      .psum_b_out   (psum_b_w[k])
    );
  end

  assign div_ctl.start   = (state_r == cma_pkg::ST_LOAD);
  assign div_ctl.divisor = hi_cnt + 1'b1;

  cma_div u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .sum_in   (psum_a_w[hi_w]),
    .quot_out (quot_a),
    .done     (div_done_a)
  );

  cma_div u_div_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .sum_in   (psum_b_w[hi_w]),
    .quot_out (quot_b),
    .done     (div_done_b)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    c_nxt          = c_r;
    d_nxt          = d_r;
    last_nxt       = last_r;
    sum_cnt_nxt    = sum_cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    avg_a_nxt      = avg_a_r;
    avg_b_nxt      = avg_b_r;
    seq_end_nxt    = seq_end_r;
    burst_last_nxt = burst_last_r;
    in_stall       = (state_r != cma_pkg::ST_IDLE);

    case (state_r)
      cma_pkg::ST_IDLE: begin
        if (accept) begin
          c_nxt       = c_acc;
          last_nxt    = in_last_sample;
          sum_cnt_nxt = '0;
          count_nxt   = in_last_sample ? '0 : c_acc;
          if (in_last_sample) begin
            // Flush every pending position, oldest first.
            d_nxt     = (cm1_acc < CW'(cma_pkg::HALF_SPAN)) ? cm1_acc
                                                            : CW'(cma_pkg::HALF_SPAN);
            state_nxt = cma_pkg::ST_SUM;
          end else if (c_acc >= CW'(cma_pkg::HALF_SPAN + 1)) begin
            d_nxt     = CW'(cma_pkg::HALF_SPAN);
            state_nxt = cma_pkg::ST_SUM;
          end
        end
      end
      cma_pkg::ST_SUM: begin
        sum_cnt_nxt = sum_cnt_r + 1'b1;
        if (sum_cnt_r == IW'(cma_pkg::SPAN - 1)) begin
          state_nxt = cma_pkg::ST_LOAD;
        end
      end
      cma_pkg::ST_LOAD: begin
        state_nxt = cma_pkg::ST_DIV;
      end
      cma_pkg::ST_DIV: begin
        if (div_done_a) begin
          state_nxt = cma_pkg::ST_EMIT;
        end
      end
      cma_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          avg_a_nxt      = quot_a;
          avg_b_nxt      = mode_r ? quot_b : '0;
          seq_end_nxt    = last_r && (d_r == '0);
          burst_last_nxt = !last_r || (d_r == '0);
          if (!last_r || (d_r == '0)) begin
            state_nxt = cma_pkg::ST_IDLE;
          end else begin
            d_nxt     = d_r - 1'b1;
            state_nxt = cma_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = cma_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write) begin
        mode_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    c_r          <= c_nxt;
    d_r          <= d_nxt;
    last_r       <= last_nxt;
    sum_cnt_r    <= sum_cnt_nxt;
    avg_a_r      <= avg_a_nxt;
    avg_b_r      <= avg_b_nxt;
    seq_end_r    <= seq_end_nxt;
    burst_last_r <= burst_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_average_a    = avg_a_r;
  assign out_average_b    = avg_b_r;
  assign out_sequence_end = seq_end_r;
  assign out_burst_last   = burst_last_r;

  // The position count never passes the window length.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(cma_pkg::SPAN))
    else $error("position count beyond window length");

  // A result is only taken from a cell holding a sample of this sequence.
  a_hi_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cma_pkg::ST_EMIT) |-> (hi_cnt < c_r))
    else $error("window reaches past the start of the sequence");

  // Both channel dividers run in lockstep.
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    div_done_a == div_done_b)
    else $error("channel dividers out of step");

  // A division only finishes while the sequencer is waiting for it.
  a_div_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(div_done_a) |-> (state_r == cma_pkg::ST_DIV))
    else $error("divider finished outside its wait state");

  // A final sample closes the sequence.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_sample) |=> (count_r == '0))
    else $error("position count not cleared after final sample");

endmodule

`default_nettype wire

// ===== test/moving_average_checker.sv =====
// Checker for the centred moving-average filter: follows the input, result and
// configuration ports, predicts every windowed mean and compares it on output.
// Depends on cma_pkg for the sample type and the window span.
module moving_average_checker
  import cma_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  sample_t     in_sample_a,
  input  sample_t     in_sample_b,
  input  logic        in_last_sample,
  input  logic        out_valid,
  input  logic        out_stall,
  input  sample_t     out_average_a,
  input  sample_t     out_average_b,
  input  logic        out_sequence_end,
  input  logic        out_burst_last,
  input  logic        cfg_write,
  input  logic        cfg_data,
  output int unsigned errors_seen,
  output int unsigned results_owed
);

  typedef struct packed {
    sample_t average_a;
    sample_t average_b;
    logic    sequence_end;
    logic    burst_last;
  } mean_result_t;

  // Recent samples, newest at index 0, and the number held in this sequence.
  sample_t      hist_a [SPAN];
  sample_t      hist_b [SPAN];
  int           held;
  logic         both_channels;
  mean_result_t owed_means [$];
  int unsigned  errs;

  // Mean over hist[lo..hi], rounded to nearest with ties away from zero.
  function automatic sample_t window_mean(input bit use_b, input int lo, input int hi);
    longint total;
    longint count;
    longint mag;
    int     k;
    total = 0;
    for (k = lo; k <= hi; k++) begin
      total += use_b ? longint'(hist_b[k]) : longint'(hist_a[k]);
    end
    count = hi - lo + 1;
    mag = (total < 0) ? -total : total;
    mag = (mag + count / 2) / count;
    return sample_t'((total < 0) ? -mag : mag);
  endfunction

  task automatic predict_means(input sample_t a, input sample_t b, input logic last);
    int           k;
    int           first;
    int           lo;
    int           hi;
    mean_result_t r;
    for (k = SPAN - 1; k > 0; k--) begin
      hist_a[k] = hist_a[k-1];
      hist_b[k] = hist_b[k-1];
    end
    hist_a[0] = a;
    hist_b[0] = b;
    if (held < SPAN) held++;
    if (!last && held < HALF_SPAN + 1) return;
    if (last) first = (held - 1 < HALF_SPAN) ? held - 1 : HALF_SPAN;
    else first = HALF_SPAN;
    // k is the age of the output position relative to the newest sample.
    for (k = first; k >= 0; k--) begin
      lo = (k >= HALF_SPAN) ? k - HALF_SPAN : 0;
      hi = (k + HALF_SPAN > held - 1) ? held - 1 : k + HALF_SPAN;
      r.average_a    = window_mean(1'b0, lo, hi);
      r.average_b    = both_channels ? window_mean(1'b1, lo, hi) : '0;
      r.sequence_end = last && k == 0;
      r.burst_last   = !last || k == 0;
      owed_means.push_back(r);
      if (!last) break;
    end
    if (last) held = 0;
  endtask

  task automatic check_result();
    mean_result_t want;
    if (owed_means.size() == 0) begin
      $error("result with none owed: average_a %0d, average_b %0d",
             out_average_a, out_average_b);
      errs++;
      return;
    end
    want = owed_means.pop_front();
    if (out_average_a !== want.average_a) begin
      $error("average_a: expected %0d, actual %0d", want.average_a, out_average_a);
      errs++;
    end
    if (out_average_b !== want.average_b) begin
      $error("average_b: expected %0d, actual %0d", want.average_b, out_average_b);
      errs++;
    end
    if (out_sequence_end !== want.sequence_end) begin
      $error("sequence_end: expected %0b, actual %0b", want.sequence_end, out_sequence_end);
      errs++;
    end
    if (out_burst_last !== want.burst_last) begin
      $error("burst_last: expected %0b, actual %0b", want.burst_last, out_burst_last);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hist_a = '{default: '0};
      hist_b = '{default: '0};
      held = 0;
      both_channels = 1'b0;
      owed_means.delete();
      errs = 0;
    end else begin
      if (cfg_write) both_channels = cfg_data;
      if (in_valid && !in_stall) predict_means(in_sample_a, in_sample_b, in_last_sample);
      if (out_valid && !out_stall) check_result();
    end
    results_owed <= owed_means.size();
    errors_seen  <= errs;
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the centred moving-average filter testbench: clock, reset, stimulus,
// output back-pressure and the verdict. Depends on cma_pkg, the filter RTL and
// moving_average_checker, which predicts and compares every result.
module tb_top;
  import cma_pkg::*;

  // This limit lies far beyond any correct run, the slowest items and all
  // their stalls included.
  localparam int LIMIT_CYCLES = 400000;
  // Longest time the block may stay busy with an item that owes no result.
  localparam int DRAIN_CYCLES = 120;

  localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  sample_t     in_sample_a    = '0;
  sample_t     in_sample_b    = '0;
  logic        in_last_sample = 1'b0;
  logic        out_stall      = 1'b0;
  logic        cfg_write      = 1'b0;
  logic        cfg_data       = 1'b0;
  logic        in_stall;
  logic        out_valid;
  sample_t     out_average_a;
  sample_t     out_average_b;
  logic        out_sequence_end;
  logic        out_burst_last;
  int unsigned errors_seen;
  int unsigned results_owed;

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int send_idle_pct = 24;
  int stall_pct     = 56;
  int cycle_count   = 0;

  centered_moving_average dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_a      (in_sample_a),
    .in_sample_b      (in_sample_b),
    .in_last_sample   (in_last_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_average_a    (out_average_a),
    .out_average_b    (out_average_b),
    .out_sequence_end (out_sequence_end),
    .out_burst_last   (out_burst_last),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data)
  );

  moving_average_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_a      (in_sample_a),
    .in_sample_b      (in_sample_b),
    .in_last_sample   (in_last_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_average_a    (out_average_a),
    .out_average_b    (out_average_b),
    .out_sequence_end (out_sequence_end),
    .out_burst_last   (out_burst_last),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .errors_seen      (errors_seen),
    .results_owed     (results_owed)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The receiver stalls at random; with the percentage at zero it never does.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: a hung handshake or a result that never arrives ends up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Samples are a mix of the two extremes, small values near zero (which
  // exercise the rounding ties) and values spread over the whole range.
  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0:       return S_MAX;
      1:       return S_MIN;
      2, 3:    return sample_t'(int'($urandom_range(8)) - 4);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // Offers one sample after a random idle gap and returns once the transfer
  // has taken place. Valid is left high so that a following sample can go
  // straight out; the next call or settle() decides whether it drops.
  task automatic send_sample(input sample_t a, input sample_t b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample_a    <= a;
    in_sample_b    <= b;
    in_last_sample <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Brings the block to rest: no further transfers offered, every owed result
  // received, and enough extra cycles for an item that owes none to finish.
  // The first edge lets the count of owed results take in the last transfer.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only ever called while the block is at rest.
  task automatic set_mode(input logic both);
    cfg_data  <= both;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Whole sequences of random length: mostly short ones, which keep the
  // clipped windows at both ends busy, and now and then a long one that
  // fills the window completely. With switch_modes set, the channel mode is
  // changed at random between sequences.
  task automatic run_sequences(input int target, input bit switch_modes);
    int sent;
    int len;
    int i;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 8);
      for (i = 0; i < len; i++) begin
        send_sample(random_sample(), random_sample(), i == len - 1);
      end
      sent += len;
      if (switch_modes && $urandom_range(3) == 0) begin
        settle();
        set_mode(1'(int'($urandom_range(1))));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, both channels filtered.
    set_mode(1'b1);
    // A sequence of a single sample: its window holds only itself.
    send_sample(S_MAX, S_MIN, 1'b1);
    // Two samples: both positions flush at once, windows clipped at both
    // ends; the sums of opposite extremes give negative ties.
    send_sample(S_MIN, S_MAX, 1'b0);
    send_sample(S_MAX, S_MIN, 1'b1);
    // Three samples: the first two give nothing, the last gives the largest
    // possible burst of results.
    send_sample(S_MAX, S_MAX, 1'b0);
    send_sample(S_MAX, S_MAX, 1'b0);
    send_sample(S_MIN, -sample_t'(1), 1'b1);
    // A longer sequence that fills the window, with small values whose
    // means land on negative halves.
    send_sample(sample_t'(1),  -sample_t'(3), 1'b0);
    send_sample(-sample_t'(2), sample_t'(2),  1'b0);
    send_sample(S_MAX,         -sample_t'(1), 1'b0);
    send_sample(S_MIN,         sample_t'(1),  1'b0);
    send_sample(sample_t'(3),  S_MIN,         1'b0);
    send_sample(sample_t'(0),  S_MAX,         1'b0);
    send_sample(-sample_t'(1), sample_t'(5),  1'b1);
    // Mode change in the middle of a sequence: the second channel is stored
    // while only the first is filtered, then used once both are filtered.
    settle();
    set_mode(1'b0);
    send_sample(sample_t'(5),  sample_t'(7),  1'b0);
    send_sample(-sample_t'(6), -sample_t'(9), 1'b0);
    send_sample(S_MAX,         S_MIN,         1'b0);
    settle();
    set_mode(1'b1);
    send_sample(S_MIN,         S_MAX,         1'b0);
    send_sample(sample_t'(2),  -sample_t'(2), 1'b0);
    send_sample(-sample_t'(4), sample_t'(4),  1'b1);
    settle();

    // Random part in three stretches: a slow receiver, then a slow sender,
    // then both at full rate with the mode changing between sequences.
    set_mode(1'b0);
    run_sequences(30, 1'b0);
    settle();
    send_idle_pct <= 56;
    stall_pct     <= 24;
    set_mode(1'b1);
    run_sequences(30, 1'b0);
    settle();
    send_idle_pct <= 0;
    stall_pct     <= 0;
    run_sequences(30, 1'b1);
    settle();

    if (errors_seen == 0 && results_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cma_pkg.sv
sv/cma_cell.sv
sv/cma_div.sv
sv/centered_moving_average.sv
test/moving_average_checker.sv
test/tb_top.sv
